/* hw/rtl/coa_pkg.sv */
// Shared types and codes for the core ownership allocator.
// Used by the sequencer, the core table and the top level; no dependencies.
package coa_pkg;

  // Field widths fixed by the item format.
  localparam int OWNER_W  = 5;
  localparam int COUNT_W  = 5;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // Action codes carried by an input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR_ALL  = 3'd0,
    ACT_PREASSIGN  = 3'd1,
    ACT_ADD        = 3'd2,
    ACT_YIELD_ONE  = 3'd3,
    ACT_YIELD_DOWN = 3'd4
  } action_t;

  // Status codes carried by a result item.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_SCAN,
    S_DROP,
    S_WRITEBACK,
    S_DONE
  } state_t;

  // Write command from the sequencer to the core table.
  typedef struct packed {
    logic wr_en;     // write owner and busy bit at the write index
    logic busy_val;  // busy bit value written with the owner
    logic clear;     // mark every core idle
  } tbl_cmd_t;

endpackage

/* hw/rtl/coa_core_table.sv */
// Core owner table: owner numbers in a synchronous memory, busy bits in flops.
// Depends on coa_pkg for the command struct.
module coa_core_table #(
  parameter int N_CORES = 28,
  parameter int CI_W    = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  coa_pkg::tbl_cmd_t            cmd,
  input  logic [CI_W-1:0]              wr_idx,
  input  logic [coa_pkg::OWNER_W-1:0]  wr_owner,
  input  logic [CI_W-1:0]              rd_idx,
  output logic                         rd_busy,
  output logic [coa_pkg::OWNER_W-1:0]  rd_owner
);
  import coa_pkg::*;

  logic [OWNER_W-1:0] owner_mem [N_CORES];
  logic [N_CORES-1:0] busy;

  // Owner memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      owner_mem[wr_idx] <= wr_owner;
    end
    rd_owner <= owner_mem[rd_idx];
  end

  // Busy bits act as entry valid bits; an idle entry ignores its stored owner.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      busy <= '0;
    end else if (cmd.wr_en) begin
      busy[wr_idx] <= cmd.busy_val;
    end
  end

  // The busy bit is read alongside the owner so both refer to the same entry.
  always_ff @(posedge clk) begin
    rd_busy <= busy[rd_idx];
  end

endmodule

/* hw/rtl/coa_count_mem.sv */
// Per-owner core counts in a synchronous memory with per-entry valid bits.
// Depends on coa_pkg only by convention; all widths come from parameters.
module coa_count_mem #(
  parameter int NUM_OWNERS = 32,
  parameter int OW         = 5,
  parameter int CNT_W      = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             wr_en,
  input  logic [OW-1:0]    wr_addr,
  input  logic [CNT_W-1:0] wr_data,
  input  logic [OW-1:0]    rd_addr,
  output logic [CNT_W-1:0] rd_data
);
  import coa_pkg::*;

  logic [CNT_W-1:0]      cnt_mem [NUM_OWNERS];
  logic [NUM_OWNERS-1:0] vld;
  logic [CNT_W-1:0]      rd_raw;
  logic                  rd_vld;

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rd_raw <= cnt_mem[rd_addr];
  end

  // Valid bits; an entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[rd_addr];
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

/* hw/rtl/coa_seq.sv */
// Sequencer: decodes an item, scans the core table one entry per cycle
// (paused by S_DROP), updates the count memory and holds the result register.
// Depends on coa_pkg for codes, states and the table command struct.
module coa_seq #(
  parameter int N_CORES    = 28,
  parameter int NUM_OWNERS = 32,
  parameter int CI_W       = 5,
  parameter int OW         = 5,
  parameter int CNT_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [coa_pkg::ACTION_W-1:0]  action,
  input  logic [coa_pkg::OWNER_W-1:0]   owner,
  input  logic [coa_pkg::COUNT_W-1:0]   core_count,
  // Result item channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [coa_pkg::STATUS_W-1:0]  status,
  output logic [4:0]                    last_core,
  output logic [coa_pkg::COUNT_W-1:0]   owner_cores,
  output logic                          owner_changed,
  // Core table
  output coa_pkg::tbl_cmd_t             tbl_cmd,
  output logic [CI_W-1:0]               tbl_wr_idx,
  output logic [coa_pkg::OWNER_W-1:0]   tbl_wr_owner,
  output logic [CI_W-1:0]               tbl_rd_idx,
  input  logic                          tbl_busy,
  input  logic [coa_pkg::OWNER_W-1:0]   tbl_owner,
  // Count memory
  output logic                          cnt_clear,
  output logic                          cnt_we,
  output logic [OW-1:0]                 cnt_waddr,
  output logic [CNT_W-1:0]              cnt_wdata,
  output logic [OW-1:0]                 cnt_raddr,
  input  logic [CNT_W-1:0]              cnt_rd
);
  import coa_pkg::*;

  // Common width for comparing counts against the 5-bit request field.
  localparam int CW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  state_t              state, state_next;
  logic [ACTION_W-1:0] act_q, act_q_next;
  logic [OWNER_W-1:0]  own_q, own_q_next;
  logic [COUNT_W-1:0]  cin_q, cin_q_next;
  logic [OWNER_W-1:0]  drop_owner, drop_owner_next;
  logic [CNT_W-1:0]    own_cnt, own_cnt_next;
  logic [CNT_W-1:0]    remain, remain_next;
  logic [CNT_W-1:0]    pre_ptr, pre_ptr_next;
  logic [CI_W-1:0]     idx, idx_next;
  logic [CI_W-1:0]     scan_k, scan_k_next;
  logic [CI_W-1:0]     search_ptr, search_ptr_next;
  logic [CI_W-1:0]     last_idx, last_idx_next;
  logic [STATUS_W-1:0] status_q, status_q_next;
  logic                changed_q, changed_q_next;
  logic                out_valid_next;
  logic                out_load;

  // Next entry in scan order, wrapping at the table end.
  function automatic logic [CI_W-1:0] wrap_inc(input logic [CI_W-1:0] i);
    return (i == CI_W'(N_CORES - 1)) ? '0 : i + 1'b1;
  endfunction

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      search_ptr <= '0;
      pre_ptr    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      search_ptr <= search_ptr_next;
      pre_ptr    <= pre_ptr_next;
      out_valid  <= out_valid_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    act_q      <= act_q_next;
    own_q      <= own_q_next;
    cin_q      <= cin_q_next;
    drop_owner <= drop_owner_next;
    own_cnt    <= own_cnt_next;
    remain     <= remain_next;
    idx        <= idx_next;
    scan_k     <= scan_k_next;
    last_idx   <= last_idx_next;
    status_q   <= status_q_next;
    changed_q  <= changed_q_next;
  end

  // Result register, loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= status_q;
      last_core     <= 5'(last_idx);
      owner_cores   <= COUNT_W'(own_cnt);
      owner_changed <= changed_q;
    end
  end

  // Next state, memory commands and result loading.
  always_comb begin
    logic             own_ok;
    logic             hit_own;
    logic             last_scan;
    logic [CW-1:0]    room;
    logic [CW-1:0]    cin_w;
    logic [CW-1:0]    grant_w;
    logic [CNT_W-1:0] dec;

    state_next      = state;
    act_q_next      = act_q;
    own_q_next      = own_q;
    cin_q_next      = cin_q;
    drop_owner_next = drop_owner;
    own_cnt_next    = own_cnt;
    remain_next     = remain;
    pre_ptr_next    = pre_ptr;
    idx_next        = idx;
    scan_k_next     = scan_k;
    search_ptr_next = search_ptr;
    last_idx_next   = last_idx;
    status_q_next   = status_q;
    changed_q_next  = changed_q;

    tbl_cmd      = '0;
    tbl_wr_idx   = idx;
    tbl_wr_owner = own_q;
    cnt_clear    = 1'b0;
    cnt_we       = 1'b0;
    cnt_waddr    = OW'(own_q);
    cnt_wdata    = own_cnt;
    cnt_raddr    = (state == S_IDLE) ? OW'(owner) : OW'(tbl_owner);

    in_ready = (state == S_IDLE);
    out_load = 1'b0;

    own_ok    = int'(own_q) < NUM_OWNERS;
    hit_own   = tbl_busy && (tbl_owner == own_q);
    last_scan = (scan_k == CI_W'(N_CORES - 1));
    room      = CW'(N_CORES) - CW'(pre_ptr);
    cin_w     = CW'(cin_q);
    grant_w   = (cin_w < room) ? cin_w : room;
    dec       = (own_cnt != '0) ? own_cnt - 1'b1 : own_cnt;

    case (state)
      // Take an item and start the owner's count read.
      S_IDLE: begin
        if (in_valid) begin
          act_q_next = action;
          own_q_next = owner;
          cin_q_next = core_count;
          state_next = S_COUNT;
        end
      end

      // Owner count is here; decode the action.
      S_COUNT: begin
        own_cnt_next   = cnt_rd;
        last_idx_next  = '0;
        changed_q_next = 1'b0;
        status_q_next  = ST_DONE;
        state_next     = S_DONE;
        if (act_q == ACT_CLEAR_ALL) begin
          changed_q_next = own_ok && (cnt_rd != '0);
          own_cnt_next   = '0;
          pre_ptr_next   = '0;
          tbl_cmd.clear  = 1'b1;
          cnt_clear      = 1'b1;
        end else if (!own_ok) begin
          status_q_next = ST_NO_MATCH;
          own_cnt_next  = '0;
        end else begin
          case (act_q)
            ACT_PREASSIGN: begin
              if (grant_w < cin_w) begin
                status_q_next = ST_SATURATED;
              end
              remain_next = CNT_W'(grant_w);
              if (grant_w != '0) begin
                idx_next   = CI_W'(pre_ptr);
                state_next = S_SCAN;
              end
            end
            ACT_ADD, ACT_YIELD_ONE, ACT_YIELD_DOWN: begin
              status_q_next = ST_NO_MATCH;
              idx_next      = search_ptr;
              scan_k_next   = '0;
              state_next    = S_SCAN;
            end
            default: begin
              status_q_next = ST_NO_MATCH;
            end
          endcase
        end
      end

      // One table entry per cycle, paused by S_DROP; the next entry's read is issued meanwhile.
      S_SCAN: begin
        case (act_q)
          ACT_PREASSIGN: begin
            tbl_cmd.wr_en    = 1'b1;
            tbl_cmd.busy_val = 1'b1;
            last_idx_next    = idx;
            changed_q_next   = 1'b1;
            pre_ptr_next     = pre_ptr + 1'b1;
            remain_next      = remain - 1'b1;
            if (hit_own) begin
              own_cnt_next = dec + 1'b1;
            end else begin
              own_cnt_next = own_cnt + 1'b1;
            end
            if (remain != CNT_W'(1)) begin
              idx_next = idx + 1'b1;
            end
            if (tbl_busy && !hit_own) begin
              // The core is taken from another owner, whose count drops.
              drop_owner_next = tbl_owner;
              state_next      = S_DROP;
            end else if (remain == CNT_W'(1)) begin
              state_next = S_WRITEBACK;
            end
          end
          ACT_ADD: begin
            if (!tbl_busy) begin
              tbl_cmd.wr_en    = 1'b1;
              tbl_cmd.busy_val = 1'b1;
              own_cnt_next     = own_cnt + 1'b1;
              search_ptr_next  = wrap_inc(search_ptr);
              last_idx_next    = idx;
              changed_q_next   = 1'b1;
              status_q_next    = ST_DONE;
              state_next       = S_WRITEBACK;
            end else if (last_scan) begin
              state_next = S_DONE;
            end else begin
              idx_next    = wrap_inc(idx);
              scan_k_next = scan_k + 1'b1;
            end
          end
          ACT_YIELD_ONE: begin
            if (hit_own) begin
              tbl_cmd.wr_en   = 1'b1;
              own_cnt_next    = dec;
              search_ptr_next = wrap_inc(search_ptr);
              last_idx_next   = idx;
              changed_q_next  = 1'b1;
              status_q_next   = ST_DONE;
              state_next      = S_WRITEBACK;
            end else if (last_scan) begin
              state_next = S_DONE;
            end else begin
              idx_next    = wrap_inc(idx);
              scan_k_next = scan_k + 1'b1;
            end
          end
          ACT_YIELD_DOWN: begin
            if (hit_own) begin
              tbl_cmd.wr_en   = 1'b1;
              own_cnt_next    = dec;
              search_ptr_next = idx;
              last_idx_next   = idx;
              changed_q_next  = 1'b1;
              status_q_next   = ST_DONE;
            end
            if (hit_own && (CW'(dec) <= cin_w)) begin
              state_next = S_WRITEBACK;
            end else if (last_scan) begin
              state_next = (hit_own || changed_q) ? S_WRITEBACK : S_DONE;
            end else begin
              idx_next    = wrap_inc(idx);
              scan_k_next = scan_k + 1'b1;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      // The displaced owner's count arrived; write it back one lower.
      S_DROP: begin
        cnt_we    = 1'b1;
        cnt_waddr = OW'(drop_owner);
        cnt_wdata = (cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
        state_next = (remain == '0) ? S_WRITEBACK : S_SCAN;
      end

      // Store the owner's new count.
      S_WRITEBACK: begin
        cnt_we     = 1'b1;
        state_next = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !out_ready);
    tbl_rd_idx     = idx_next;
  end

endmodule

/* hw/rtl/core_ownership_allocator.sv */
// Top level of the core ownership allocator: sequencer, core table, counts.
// Depends on coa_pkg, coa_core_table, coa_count_mem and coa_seq.
//
// Next-fit allocator of N_CORES cores among NUM_OWNERS clients. One item is
// processed at a time; a result is held in an output register so the next item
// can be taken while it waits. The table is visited one entry per cycle through
// the owner memory read port. clear_all, out-of-range owners, unknown actions
// and a preassign that grants nothing visit no table entry; add and yield_one
// stop at the first matching core, or after a full pass when none matches;
// yield_down scans until the last core it frees; preassign visits one entry
// per core granted and pauses for each granted core that was taken from another
// owner, since that owner's count needs its own read and write on the count
// memory port. The sequencer is ready for the next item once its predecessor's
// result is loaded.
module core_ownership_allocator #(
  parameter int N_CORES    = 28,
  parameter int NUM_OWNERS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [coa_pkg::ACTION_W-1:0]  action,
  input  logic [coa_pkg::OWNER_W-1:0]   owner,
  input  logic [coa_pkg::COUNT_W-1:0]   core_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [coa_pkg::STATUS_W-1:0]  status,
  output logic [4:0]                    last_core,
  output logic [coa_pkg::COUNT_W-1:0]   owner_cores,
  output logic                          owner_changed
);
  import coa_pkg::*;

  localparam int CI_W  = $clog2(N_CORES);
  localparam int OW    = $clog2(NUM_OWNERS);
  localparam int CNT_W = $clog2(N_CORES + 1);

  tbl_cmd_t           tbl_cmd;
  logic [CI_W-1:0]    tbl_wr_idx;
  logic [OWNER_W-1:0] tbl_wr_owner;
  logic [CI_W-1:0]    tbl_rd_idx;
  logic               tbl_busy;
  logic [OWNER_W-1:0] tbl_owner;
  logic               cnt_clear;
  logic               cnt_we;
  logic [OW-1:0]      cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [OW-1:0]      cnt_raddr;
  logic [CNT_W-1:0]   cnt_rd;

  // Control sequencer and result register.
  coa_seq #(
    .N_CORES    (N_CORES),
    .NUM_OWNERS (NUM_OWNERS),
    .CI_W       (CI_W),
    .OW         (OW),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .owner         (owner),
    .core_count    (core_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .last_core     (last_core),
    .owner_cores   (owner_cores),
    .owner_changed (owner_changed),
    .tbl_cmd       (tbl_cmd),
    .tbl_wr_idx    (tbl_wr_idx),
    .tbl_wr_owner  (tbl_wr_owner),
    .tbl_rd_idx    (tbl_rd_idx),
    .tbl_busy      (tbl_busy),
    .tbl_owner     (tbl_owner),
    .cnt_clear     (cnt_clear),
    .cnt_we        (cnt_we),
    .cnt_waddr     (cnt_waddr),
    .cnt_wdata     (cnt_wdata),
    .cnt_raddr     (cnt_raddr),
    .cnt_rd        (cnt_rd)
  );

  // Owner table with busy bits.
  coa_core_table #(
    .N_CORES (N_CORES),
    .CI_W    (CI_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tbl_cmd),
    .wr_idx   (tbl_wr_idx),
    .wr_owner (tbl_wr_owner),
    .rd_idx   (tbl_rd_idx),
    .rd_busy  (tbl_busy),
    .rd_owner (tbl_owner)
  );

  // Per-owner core counts.
  coa_count_mem #(
    .NUM_OWNERS (NUM_OWNERS),
    .OW         (OW),
    .CNT_W      (CNT_W)
  ) u_counts (
    .clk     (clk),
    .rst     (rst),
    .clear   (cnt_clear),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rd)
  );

`ifndef SYNTHESIS
  // A result that found no matching core never reports a changed owner.
  a_nomatch_unchanged: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_MATCH) |-> !owner_changed)
    else $error("no-match result reports a changed owner");

  // An untouched owner reports no granted or freed core.
  a_unchanged_last_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !owner_changed |-> (last_core == 5'd0))
    else $error("unchanged result carries a nonzero last core");

  // Items are handled one at a time: no accept in the cycle after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");
`endif

endmodule
